>>> rtl/nrld_pkg.sv
// ----------------------------------------------------------------------------
// nrld_pkg
// Types and constants of the nibble run-length dictionary decoder.
// ----------------------------------------------------------------------------
package nrld_pkg;

  localparam int DICT_ENTRIES = 8;
  localparam int DICT_AW      = 3;
  localparam int RUN_W        = 9;
  localparam int MAX_RES      = 4;

  typedef logic [3:0] nib_t;

  // opcodes
  localparam nib_t OP_LONG_ZERO  = 4'd0;
  localparam nib_t OP_LIT1       = 4'd1;
  localparam nib_t OP_LIT2       = 4'd2;
  localparam nib_t OP_LIT3       = 4'd3;
  localparam nib_t OP_LIT4       = 4'd4;
  localparam nib_t OP_REPEAT     = 4'd5;
  localparam nib_t OP_SHORT_ZERO = 4'd6;
  localparam nib_t OP_DICT_FIRST = 4'd7;
  localparam nib_t OP_END        = 4'd15;

  // dictionary entry types (high nibble)
  localparam nib_t DT_ONCE  = 4'h1;
  localparam nib_t DT_TWICE = 4'h2;
  localparam nib_t DT_ZERO  = 4'h6;

  localparam logic [RUN_W-1:0] LONG_RUN_BIAS  = 9'd19;
  localparam logic [RUN_W-1:0] SHORT_RUN_BIAS = 9'd3;

  localparam logic [15:0] LIMIT_RESET = 16'h2000;

  // register index, taken from paddr bit 2
  localparam logic REG_OUT_LIMIT = 1'b0;

  typedef struct packed {
    logic [3:0]  fill;
    nib_t        pend;
    logic [1:0]  need;
    nib_t        first;
    nib_t        held;
    logic        half;
    logic [15:0] bcnt;
  } blk_state_t;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  byte_val;
    logic [7:0]  rep;
    logic        partial;
    logic [15:0] bw;
    logic        ovf;
    logic        last;
  } res_t;

  typedef struct packed {
    blk_state_t st;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    logic       ended;
  } step_t;

endpackage

>>> rtl/nibble_rle_dictionary_decoder_core.sv
// ----------------------------------------------------------------------------
// nibble_rle_dictionary_decoder_core
// Nibble run-length dictionary decoder: source bytes in, byte runs and block
// end items out.
// ----------------------------------------------------------------------------
// One source byte is accepted into an input register and decoded
// combinationally, both nibbles at once, into up to four result words held in a
// four-slot result buffer whose head is the output register. A byte that
// yields zero or one result does not hold the input, so bytes can stream back
// to back while the output is ready; a byte that yields more results holds the
// input until the single result port has drained the buffer. The next
// byte is decoded as the last pending result is taken. out_limit is written
// through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module nibble_rle_dictionary_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_src_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_end,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_repeat_res,
  output logic        out_partial,
  output logic [15:0] out_bytes_written,
  output logic        out_overflow,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]             in_r;
  logic                   in_vld_r;
  nrld_pkg::blk_state_t   st_r, st_nxt;
  logic [7:0]             dict_r [nrld_pkg::DICT_ENTRIES];
  logic [15:0]            limit_r;
  nrld_pkg::res_t         slot_r [nrld_pkg::MAX_RES];
  nrld_pkg::res_t         slot_nxt [nrld_pkg::MAX_RES];
  logic [2:0]             cnt_r, cnt_nxt;

  logic                   proc_fire;
  logic                   pop;
  logic                   fill_phase;
  logic                   cfg_wr;

  nrld_pkg::step_t        s0, s1, s1c, s2;
  nrld_pkg::nib_t         sub_hi, sub_lo;
  logic [7:0]             d_hi, d_lo;
  nrld_pkg::res_t         cand [nrld_pkg::MAX_RES];
  logic [nrld_pkg::MAX_RES-1:0] cand_v;
  nrld_pkg::res_t         res_v [nrld_pkg::MAX_RES];
  logic [2:0]             nres;
  logic [2:0]             last_idx;

  // --------------------------------------------------------------------------
  // decode helpers
  // --------------------------------------------------------------------------
  function automatic nrld_pkg::step_t push_res(nrld_pkg::step_t a, nrld_pkg::res_t r);
    nrld_pkg::step_t o;
    o = a;
    if (a.n == 2'd0) begin
      o.r0 = r;
    end else begin
      o.r1 = r;
    end
    o.n = a.n + 2'd1;
    return o;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] c, logic [7:0] k);
    logic [16:0] s;
    s = {1'b0, c} + {9'd0, k};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic nrld_pkg::step_t write_run(nrld_pkg::step_t a, nrld_pkg::nib_t v,
                                               logic [nrld_pkg::RUN_W-1:0] n);
    nrld_pkg::step_t            o;
    nrld_pkg::res_t             r;
    logic [nrld_pkg::RUN_W-1:0] rem;
    logic [7:0]                 full;
    o   = a;
    rem = n;
    r   = '0;
    if (n != '0) begin
      if (o.st.half) begin
        r          = '0;
        r.byte_val = {v, o.st.held};
        r.rep      = 8'd1;
        o          = push_res(o, r);
        o.st.bcnt  = sat_add(o.st.bcnt, 8'd1);
        o.st.half  = 1'b0;
        o.st.held  = '0;
        rem        = n - 9'd1;
      end
      full = rem[8:1];
      if (full != 8'd0) begin
        r          = '0;
        r.byte_val = {v, v};
        r.rep      = full;
        o          = push_res(o, r);
        o.st.bcnt  = sat_add(o.st.bcnt, full);
      end
      if (rem[0]) begin
        o.st.held = v;
        o.st.half = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic nrld_pkg::step_t do_nibble(nrld_pkg::step_t a, logic [7:0] d,
                                               logic [15:0] lim, nrld_pkg::nib_t nb);
    nrld_pkg::step_t o;
    nrld_pkg::res_t  r;
    o = a;
    r = '0;
    if (a.st.need == 2'd0) begin
      o.st.pend = nb;
      case (nb)
        nrld_pkg::OP_LONG_ZERO, nrld_pkg::OP_LIT3, nrld_pkg::OP_REPEAT: begin
          o.st.need = 2'd2;
        end
        nrld_pkg::OP_LIT1, nrld_pkg::OP_LIT2, nrld_pkg::OP_SHORT_ZERO: begin
          o.st.need = 2'd1;
        end
        nrld_pkg::OP_LIT4: begin
          o.st.need = 2'd3;
        end
        nrld_pkg::OP_END: begin
          r.is_end   = 1'b1;
          r.byte_val = {4'd0, a.st.half ? a.st.held : 4'd0};
          r.partial  = a.st.half;
          r.bw       = a.st.bcnt;
          r.ovf      = (a.st.bcnt > lim);
          o          = push_res(o, r);
          o.st       = '0;
          o.ended    = 1'b1;
        end
        default: begin
          case (d[7:4])
            nrld_pkg::DT_TWICE: o = write_run(o, d[3:0], 9'd2);
            nrld_pkg::DT_ONCE:  o = write_run(o, d[3:0], 9'd1);
            nrld_pkg::DT_ZERO:
              o = write_run(o, 4'd0, {5'd0, d[3:0]} + nrld_pkg::SHORT_RUN_BIAS);
            default: ;
          endcase
        end
      endcase
    end else begin
      case (a.st.pend)
        nrld_pkg::OP_LONG_ZERO: begin
          if (a.st.need == 2'd2) begin
            o.st.first = nb;
          end else begin
            o = write_run(o, 4'd0, {1'b0, a.st.first, nb} + nrld_pkg::LONG_RUN_BIAS);
          end
        end
        nrld_pkg::OP_LIT1, nrld_pkg::OP_LIT3, nrld_pkg::OP_LIT4: begin
          o = write_run(o, nb, 9'd1);
        end
        nrld_pkg::OP_LIT2: begin
          o = write_run(o, nb, 9'd2);
        end
        nrld_pkg::OP_REPEAT: begin
          if (a.st.need == 2'd2) begin
            o.st.first = nb;
          end else begin
            o = write_run(o, a.st.first, {5'd0, nb} + nrld_pkg::SHORT_RUN_BIAS);
          end
        end
        nrld_pkg::OP_SHORT_ZERO: begin
          o = write_run(o, 4'd0, {5'd0, nb} + nrld_pkg::SHORT_RUN_BIAS);
        end
        default: ;
      endcase
      o.st.need = a.st.need - 2'd1;
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  assign pop       = out_valid && out_ready;
  assign proc_fire = in_vld_r && ((cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready));
  assign in_ready  = !in_vld_r || proc_fire;
  assign out_valid = (cnt_r != 3'd0);

  // --------------------------------------------------------------------------
  // decode of the registered byte
  // --------------------------------------------------------------------------
  assign fill_phase = !st_r.fill[3];
  assign sub_hi     = in_r[7:4] - nrld_pkg::OP_DICT_FIRST;
  assign sub_lo     = in_r[3:0] - nrld_pkg::OP_DICT_FIRST;
  assign d_hi       = dict_r[sub_hi[nrld_pkg::DICT_AW-1:0]];
  assign d_lo       = dict_r[sub_lo[nrld_pkg::DICT_AW-1:0]];

  always_comb begin
    s0       = '0;
    s0.st    = st_r;
    s1       = do_nibble(s0, d_hi, limit_r, in_r[7:4]);
    s1c      = '0;
    s1c.st   = s1.st;
    s2       = do_nibble(s1c, d_lo, limit_r, in_r[3:0]);

    cand[0]  = s1.r0;
    cand[1]  = s1.r1;
    cand[2]  = s2.r0;
    cand[3]  = s2.r1;
    cand_v[0] = !fill_phase && (s1.n >= 2'd1);
    cand_v[1] = !fill_phase && (s1.n >= 2'd2);
    cand_v[2] = !fill_phase && !s1.ended && (s2.n >= 2'd1);
    cand_v[3] = !fill_phase && !s1.ended && (s2.n >= 2'd2);

    for (int i = 0; i < nrld_pkg::MAX_RES; i++) begin
      res_v[i] = '0;
    end
    nres = 3'd0;
    for (int i = 0; i < nrld_pkg::MAX_RES; i++) begin
      if (cand_v[i]) begin
        res_v[nres[1:0]] = cand[i];
        nres             = nres + 3'd1;
      end
    end
    last_idx = nres - 3'd1;
    if (nres != 3'd0) begin
      res_v[last_idx[1:0]].last = 1'b1;
    end

    if (fill_phase) begin
      st_nxt      = st_r;
      st_nxt.fill = st_r.fill + 4'd1;
    end else if (s1.ended) begin
      st_nxt = s1.st;
    end else begin
      st_nxt = s2.st;
    end
  end

  // --------------------------------------------------------------------------
  // result buffer, slot 0 is the output register
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < nrld_pkg::MAX_RES; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (proc_fire) begin
      for (int i = 0; i < nrld_pkg::MAX_RES; i++) begin
        slot_nxt[i] = res_v[i];
      end
      cnt_nxt = nres;
    end else if (pop) begin
      for (int i = 0; i < nrld_pkg::MAX_RES - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  assign out_is_end        = slot_r[0].is_end;
  assign out_byte          = slot_r[0].byte_val;
  assign out_repeat_res    = slot_r[0].rep;
  assign out_partial       = slot_r[0].partial;
  assign out_bytes_written = slot_r[0].bw;
  assign out_overflow      = slot_r[0].ovf;
  assign out_last          = slot_r[0].last;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == nrld_pkg::REG_OUT_LIMIT);
  assign prdata = (paddr[2] == nrld_pkg::REG_OUT_LIMIT) ? {16'd0, limit_r} : 32'd0;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '0;
      cnt_r    <= 3'd0;
      limit_r  <= nrld_pkg::LIMIT_RESET;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (proc_fire) begin
        st_r <= st_nxt;
      end
      cnt_r <= cnt_nxt;
      if (cfg_wr) begin
        limit_r <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_src_byte;
    end
    if (proc_fire && fill_phase) begin
      dict_r[st_r.fill[nrld_pkg::DICT_AW-1:0]] <= in_r;
    end
    for (int i = 0; i < nrld_pkg::MAX_RES; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nibble run-length dictionary decoder core.
// ----------------------------------------------------------------------------
// Source bytes are generated as whole blocks (dictionary fill, opcode stream,
// block end) plus some noise, and sent in bursts with random gaps. Each
// accepted byte is decoded here by a behavioral decoder into the run and end
// words it should produce. Every result word is checked field by field in
// order. The out_limit register is written over APB between phases (reset
// value, zero, small, all ones, random) and read back after each write.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_src_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_end;
  logic [7:0]  out_byte;
  logic [7:0]  out_repeat_res;
  logic        out_partial;
  logic [15:0] out_bytes_written;
  logic        out_overflow;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  nibble_rle_dictionary_decoder_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_src_byte       (in_src_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_end        (out_is_end),
    .out_byte          (out_byte),
    .out_repeat_res    (out_repeat_res),
    .out_partial       (out_partial),
    .out_bytes_written (out_bytes_written),
    .out_overflow      (out_overflow),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int n_errors = 0;

  // decoder state
  logic [15:0]    lim_reg = nrld_pkg::LIMIT_RESET;
  logic [7:0]     dict_mem [nrld_pkg::DICT_ENTRIES];
  logic [3:0]     fill_cnt = '0;
  nrld_pkg::nib_t op_pend = '0;
  logic [1:0]     need_cnt = '0;
  nrld_pkg::nib_t opnd_a = '0;
  nrld_pkg::nib_t held_nib = '0;
  logic           held_ok = 1'b0;
  logic [15:0]    done_bytes = '0;

  nrld_pkg::res_t byte_results [$];
  nrld_pkg::res_t pending_runs [$];
  logic [7:0] src_bytes [$];
  nrld_pkg::nib_t nib_buf [$];

  function automatic void stage_result(logic e, logic [7:0] b, int rep, logic part,
                                       logic [15:0] bw, logic ovf);
    nrld_pkg::res_t r;
    r.is_end   = e;
    r.byte_val = b;
    r.rep      = 8'(rep);
    r.partial  = part;
    r.bw       = bw;
    r.ovf      = ovf;
    r.last     = 1'b0;
    if (byte_results.size() < nrld_pkg::MAX_RES) byte_results.push_back(r);
  endfunction

  function automatic void add_bytes(int n);
    int sum;
    sum = int'(done_bytes) + n;
    done_bytes = (sum > 65535) ? 16'hFFFF : 16'(sum);
  endfunction

  function automatic void write_nibbles(nrld_pkg::nib_t v, int n);
    int pairs;
    if (n == 0) return;
    if (held_ok) begin
      stage_result(1'b0, {v, held_nib}, 1, 1'b0, '0, 1'b0);
      add_bytes(1);
      held_ok = 1'b0;
      held_nib = '0;
      n--;
    end
    pairs = n / 2;
    if (pairs > 0) begin
      stage_result(1'b0, {v, v}, pairs, 1'b0, '0, 1'b0);
      add_bytes(pairs);
    end
    if (n % 2 == 1) begin
      held_nib = v;
      held_ok = 1'b1;
    end
  endfunction

  // returns 1 when the nibble ends the block
  function automatic bit take_nibble(nrld_pkg::nib_t nb);
    logic [7:0] d;
    if (need_cnt == 0) begin
      op_pend = nb;
      case (nb)
        nrld_pkg::OP_LONG_ZERO, nrld_pkg::OP_LIT3, nrld_pkg::OP_REPEAT: need_cnt = 2'd2;
        nrld_pkg::OP_LIT1, nrld_pkg::OP_LIT2, nrld_pkg::OP_SHORT_ZERO: need_cnt = 2'd1;
        nrld_pkg::OP_LIT4: need_cnt = 2'd3;
        nrld_pkg::OP_END: begin
          stage_result(1'b1, held_ok ? {4'h0, held_nib} : 8'h00, 0, held_ok,
                       done_bytes, done_bytes > lim_reg);
          fill_cnt = '0;
          op_pend = '0;
          need_cnt = '0;
          opnd_a = '0;
          held_nib = '0;
          held_ok = 1'b0;
          done_bytes = '0;
          return 1'b1;
        end
        default: begin
          d = dict_mem[3'(nb - nrld_pkg::OP_DICT_FIRST)];
          case (d[7:4])
            nrld_pkg::DT_TWICE: write_nibbles(d[3:0], 2);
            nrld_pkg::DT_ONCE: write_nibbles(d[3:0], 1);
            nrld_pkg::DT_ZERO:
              write_nibbles('0, int'(d[3:0]) + int'(nrld_pkg::SHORT_RUN_BIAS));
            default: ;
          endcase
        end
      endcase
      return 1'b0;
    end
    case (op_pend)
      nrld_pkg::OP_LONG_ZERO: begin
        if (need_cnt == 2) opnd_a = nb;
        else write_nibbles('0, int'(opnd_a) * 16 + int'(nb)
                               + int'(nrld_pkg::LONG_RUN_BIAS));
      end
      nrld_pkg::OP_LIT1, nrld_pkg::OP_LIT3, nrld_pkg::OP_LIT4: write_nibbles(nb, 1);
      nrld_pkg::OP_LIT2: write_nibbles(nb, 2);
      nrld_pkg::OP_REPEAT: begin
        if (need_cnt == 2) opnd_a = nb;
        else write_nibbles(opnd_a, int'(nb) + int'(nrld_pkg::SHORT_RUN_BIAS));
      end
      nrld_pkg::OP_SHORT_ZERO:
        write_nibbles('0, int'(nb) + int'(nrld_pkg::SHORT_RUN_BIAS));
      default: ;
    endcase
    need_cnt--;
    return 1'b0;
  endfunction

  function automatic void decode_src_byte(logic [7:0] b);
    nrld_pkg::res_t r;
    byte_results.delete();
    if (fill_cnt < nrld_pkg::DICT_ENTRIES) begin
      dict_mem[fill_cnt[nrld_pkg::DICT_AW-1:0]] = b;
      fill_cnt++;
      return;
    end
    if (!take_nibble(b[7:4])) void'(take_nibble(b[3:0]));
    foreach (byte_results[i]) begin
      r = byte_results[i];
      r.last = (i == byte_results.size() - 1);
      pending_runs.push_back(r);
    end
  endfunction

  // stimulus building
  function automatic logic [7:0] dict_entry();
    case ($urandom_range(0, 9))
      0, 1, 2: return {nrld_pkg::DT_ONCE, 4'($urandom)};
      3, 4, 5: return {nrld_pkg::DT_TWICE, 4'($urandom)};
      6, 7: return {nrld_pkg::DT_ZERO, 4'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_op(nrld_pkg::nib_t op);
    nib_buf.push_back(op);
    case (op)
      nrld_pkg::OP_LONG_ZERO, nrld_pkg::OP_LIT3, nrld_pkg::OP_REPEAT:
        repeat (2) nib_buf.push_back(4'($urandom));
      nrld_pkg::OP_LIT1, nrld_pkg::OP_LIT2, nrld_pkg::OP_SHORT_ZERO:
        nib_buf.push_back(4'($urandom));
      nrld_pkg::OP_LIT4: repeat (3) nib_buf.push_back(4'($urandom));
      default: ;
    endcase
  endfunction

  // end nibble either high or low in its byte; a trailing low nibble is random
  function automatic void close_block();
    nib_buf.push_back(nrld_pkg::OP_END);
    for (int i = 0; i < nib_buf.size(); i += 2)
      src_bytes.push_back({nib_buf[i], (i + 1 < nib_buf.size()) ? nib_buf[i + 1]
                                                         : nrld_pkg::nib_t'($urandom)});
    nib_buf.delete();
  endfunction

  function automatic void rand_block();
    repeat (nrld_pkg::DICT_ENTRIES) src_bytes.push_back(dict_entry());
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) src_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 24)) add_op(nrld_pkg::nib_t'($urandom_range(0, 14)));
    end
    close_block();
  endfunction

  // maximal long zero runs, drives the byte count up fast
  function automatic void long_runs(int n);
    repeat (nrld_pkg::DICT_ENTRIES) src_bytes.push_back(dict_entry());
    repeat (n) begin
      nib_buf.push_back(nrld_pkg::OP_LONG_ZERO);
      nib_buf.push_back(4'hF);
      nib_buf.push_back(4'hF);
    end
    close_block();
  endfunction

  function automatic void rand_words(int n);
    while (src_bytes.size() < n) rand_block();
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // source driver
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_src_byte(in_src_byte);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (src_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_src_byte <= src_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result sink stall pattern
  logic [7:0] ready_pat = 8'hFF;
  logic [2:0] pat_ph = '0;
  int pat_left = 0;

  always @(posedge clk) begin
    if (pat_left == 0) begin
      case ($urandom_range(0, 2))
        0: ready_pat <= 8'hFF;
        1: ready_pat <= 8'($urandom) | (8'h01 << $urandom_range(0, 7));
        default: ready_pat <= 8'($urandom) | 8'($urandom) | 8'h01;
      endcase
      pat_left <= $urandom_range(20, 120);
    end else begin
      pat_left <= pat_left - 1;
    end
    out_ready <= ready_pat[pat_ph];
    pat_ph <= pat_ph + 3'd1;
  end

  // result monitor
  always @(posedge clk) begin : mon
    nrld_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_runs.size() == 0) begin
        $error("result word with none expected");
        n_errors++;
      end else begin
        want = pending_runs.pop_front();
        check_field("is_end", want.is_end, out_is_end);
        check_field("out_byte", want.byte_val, out_byte);
        check_field("repeat_res", want.rep, out_repeat_res);
        check_field("partial", want.partial, out_partial);
        check_field("bytes_written", want.bw, out_bytes_written);
        check_field("overflow", want.ovf, out_overflow);
        check_field("last", want.last, out_last);
      end
    end
  end

  task automatic apb_xfer(logic wr, logic [2:0] addr, logic [31:0] data,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(logic [2:0] addr, logic [31:0] data);
    logic [31:0] rd;
    if (addr != '1) begin
      apb_xfer(1'b1, addr, data, rd);
      if (addr[2] == nrld_pkg::REG_OUT_LIMIT) lim_reg = data[15:0];
    end
    apb_xfer(1'b0, {nrld_pkg::REG_OUT_LIMIT, 2'b00}, '0, rd);
    check_field("prdata", lim_reg, rd[15:0]);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (src_bytes.size() > 0 || in_valid || pending_runs.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [63:0]  dir_dict;
    logic [127:0] dir_ops;
    dir_dict = 64'h15_2A_60_6F_1F_2F_00_FF;
    dir_ops  = 128'h000_1F_2A_35F_4123_5FF_60_6F_789ABCDE_0FF;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_limit('1, '0);

    // every opcode, every dictionary type, held nibble completion
    for (int i = 0; i < nrld_pkg::DICT_ENTRIES; i++)
      src_bytes.push_back(dir_dict[63 - 8 * i -: 8]);
    for (int i = 0; i < 32; i++) nib_buf.push_back(dir_ops[127 - 4 * i -: 4]);
    close_block();
    // past the reset limit
    long_runs(61);
    wait_idle();

    set_limit({~nrld_pkg::REG_OUT_LIMIT, 2'b00}, $urandom);
    set_limit({nrld_pkg::REG_OUT_LIMIT, 2'b00}, {16'($urandom), 16'h0000});
    rand_words(16);
    wait_idle();

    set_limit({nrld_pkg::REG_OUT_LIMIT, 2'b00},
              {16'($urandom), 16'($urandom_range(1, 300))});
    rand_words(24);
    wait_idle();

    // limit at its top, overflow never reported
    set_limit({nrld_pkg::REG_OUT_LIMIT, 2'b00}, {16'($urandom), 16'hFFFF});
    long_runs(3);
    rand_words(src_bytes.size() + 8);
    wait_idle();

    set_limit({nrld_pkg::REG_OUT_LIMIT, 2'b00}, $urandom);
    rand_words(12);
    wait_idle();
    repeat (20) @(posedge clk);

    if (n_errors == 0) begin
      $display("PASS nibble_rle_dictionary_decoder_core");
    end else begin
      $display("FAIL nibble_rle_dictionary_decoder_core");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL nibble_rle_dictionary_decoder_core");
    $finish;
  end

endmodule
